// ===== rtl/lpg_pkg.sv =====
// Shared types, widths and codes for the line pixel generator.
package lpg_pkg;

	localparam int COORD_BITS = 10;
	localparam int ERR_BITS   = COORD_BITS + 1;
	localparam int COLOR_BITS = 16;

	typedef logic [COORD_BITS-1:0] coord_t;
	typedef logic [ERR_BITS-1:0]   err_t;
	typedef logic [COLOR_BITS-1:0] color_t;
	typedef logic [1:0]            dir_t;

	localparam dir_t DIR_NONE = 2'd0;
	localparam dir_t DIR_POS  = 2'd1;
	localparam dir_t DIR_NEG  = 2'd3;

	localparam logic KIND_START = 1'b0;
	localparam logic KIND_NEXT  = 1'b1;

	typedef struct packed {
		logic   kind;
		coord_t x_start;
		coord_t y_start;
		coord_t x_end;
		coord_t y_end;
		color_t color;
	} item_t;

	typedef struct packed {
		coord_t x;
		coord_t y;
		color_t color;
		logic   last;
	} pixel_t;

	typedef struct packed {
		coord_t abs_dx;
		coord_t abs_dy;
		coord_t major_len;
		dir_t   x_dir;
		dir_t   y_dir;
	} line_setup_t;

endpackage

// ===== rtl/lpg_in_if.sv =====
// Command channel: start or next-pixel beats with line endpoints and color.
interface lpg_in_if;
	logic            valid;
	logic            ready;
	logic            kind;
	lpg_pkg::coord_t x_start;
	lpg_pkg::coord_t y_start;
	lpg_pkg::coord_t x_end;
	lpg_pkg::coord_t y_end;
	lpg_pkg::color_t color;

	modport source (output valid, kind, x_start, y_start, x_end, y_end, color, input ready);
	modport sink   (input valid, kind, x_start, y_start, x_end, y_end, color, output ready);
endinterface

// ===== rtl/lpg_out_if.sv =====
// Pixel channel: one beat per emitted pixel.
interface lpg_out_if;
	logic            valid;
	logic            ready;
	lpg_pkg::coord_t pixel_x;
	lpg_pkg::coord_t pixel_y;
	lpg_pkg::color_t pixel_color;
	logic            last;

	modport source (output valid, pixel_x, pixel_y, pixel_color, last, input ready);
	modport sink   (input valid, pixel_x, pixel_y, pixel_color, last, output ready);
endinterface

// ===== rtl/lpg_setup.sv =====
// Line setup: absolute deltas, step directions and major distance.
module lpg_setup (
	input  lpg_pkg::item_t       item,
	output lpg_pkg::line_setup_t setup
);

	always_comb begin
		setup = '0;
		if (item.x_end > item.x_start) begin
			setup.abs_dx = item.x_end - item.x_start;
			setup.x_dir  = lpg_pkg::DIR_POS;
		end else if (item.x_end == item.x_start) begin
			setup.abs_dx = '0;
			setup.x_dir  = lpg_pkg::DIR_NONE;
		end else begin
			setup.abs_dx = item.x_start - item.x_end;
			setup.x_dir  = lpg_pkg::DIR_NEG;
		end
		if (item.y_end > item.y_start) begin
			setup.abs_dy = item.y_end - item.y_start;
			setup.y_dir  = lpg_pkg::DIR_POS;
		end else if (item.y_end == item.y_start) begin
			setup.abs_dy = '0;
			setup.y_dir  = lpg_pkg::DIR_NONE;
		end else begin
			setup.abs_dy = item.y_start - item.y_end;
			setup.y_dir  = lpg_pkg::DIR_NEG;
		end
		setup.major_len = (setup.abs_dx > setup.abs_dy) ? setup.abs_dx : setup.abs_dy;
	end

endmodule

// ===== rtl/lpg_engine.sv =====
// Line state and error-accumulator stepping; one beat processed per cycle while go is high.
module lpg_engine (
	input  logic            clk,
	input  logic            arst_n,
	input  logic            go,
	input  lpg_pkg::item_t  item,
	output logic            emit,
	output lpg_pkg::pixel_t pixel
);

	lpg_pkg::line_setup_t setup;

	logic            active_q;
	lpg_pkg::coord_t cur_x_q;
	lpg_pkg::coord_t cur_y_q;
	lpg_pkg::dir_t   x_dir_q;
	lpg_pkg::dir_t   y_dir_q;
	lpg_pkg::coord_t abs_dx_q;
	lpg_pkg::coord_t abs_dy_q;
	lpg_pkg::coord_t major_len_q;
	lpg_pkg::err_t   x_err_q;
	lpg_pkg::err_t   y_err_q;
	lpg_pkg::err_t   step_count_q;
	lpg_pkg::color_t line_color_q;

	lpg_pkg::err_t   major_ext;
	lpg_pkg::err_t   last_count;
	lpg_pkg::err_t   x_sum;
	lpg_pkg::err_t   y_sum;
	logic            x_move;
	logic            y_move;
	logic            is_last;
	lpg_pkg::err_t   x_err_d;
	lpg_pkg::err_t   y_err_d;
	lpg_pkg::coord_t cur_x_d;
	lpg_pkg::coord_t cur_y_d;

	function automatic lpg_pkg::coord_t apply_dir(lpg_pkg::coord_t pos, lpg_pkg::dir_t dir);
		lpg_pkg::coord_t res;
		case (dir)
			lpg_pkg::DIR_POS: res = pos + lpg_pkg::coord_t'(1);
			lpg_pkg::DIR_NEG: res = pos - lpg_pkg::coord_t'(1);
			default:          res = pos;
		endcase
		return res;
	endfunction

	lpg_setup u_setup (
		.item  (item),
		.setup (setup)
	);

	always_comb begin
		major_ext  = {1'b0, major_len_q};
		last_count = major_ext + lpg_pkg::err_t'(1);
		is_last    = (step_count_q >= last_count);
		x_sum      = x_err_q + {1'b0, abs_dx_q};
		y_sum      = y_err_q + {1'b0, abs_dy_q};
		x_move     = (x_sum > major_ext);
		y_move     = (y_sum > major_ext);
		x_err_d    = x_move ? (x_sum - major_ext) : x_sum;
		y_err_d    = y_move ? (y_sum - major_ext) : y_sum;
		cur_x_d    = x_move ? apply_dir(cur_x_q, x_dir_q) : cur_x_q;
		cur_y_d    = y_move ? apply_dir(cur_y_q, y_dir_q) : cur_y_q;
	end

	assign emit        = go && (item.kind == lpg_pkg::KIND_NEXT) && active_q;
	assign pixel.x     = cur_x_q;
	assign pixel.y     = cur_y_q;
	assign pixel.color = line_color_q;
	assign pixel.last  = is_last;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			active_q     <= 1'b0;
			cur_x_q      <= '0;
			cur_y_q      <= '0;
			x_dir_q      <= lpg_pkg::DIR_NONE;
			y_dir_q      <= lpg_pkg::DIR_NONE;
			abs_dx_q     <= '0;
			abs_dy_q     <= '0;
			major_len_q  <= '0;
			x_err_q      <= '0;
			y_err_q      <= '0;
			step_count_q <= '0;
			line_color_q <= '0;
		end else if (go) begin
			if (item.kind == lpg_pkg::KIND_START) begin
				active_q     <= 1'b1;
				cur_x_q      <= item.x_start;
				cur_y_q      <= item.y_start;
				x_dir_q      <= setup.x_dir;
				y_dir_q      <= setup.y_dir;
				abs_dx_q     <= setup.abs_dx;
				abs_dy_q     <= setup.abs_dy;
				major_len_q  <= setup.major_len;
				x_err_q      <= '0;
				y_err_q      <= '0;
				step_count_q <= '0;
				line_color_q <= item.color;
			end else if (active_q) begin
				if (is_last) begin
					active_q <= 1'b0;
				end else begin
					step_count_q <= step_count_q + lpg_pkg::err_t'(1);
					x_err_q      <= x_err_d;
					y_err_q      <= y_err_d;
					cur_x_q      <= cur_x_d;
					cur_y_q      <= cur_y_d;
				end
			end
		end
	end

endmodule

// ===== rtl/line_pixel_generator_core.sv =====
// Line pixel generator top level: input register, line engine, output register.
//
// Channels: line_in carries command beats. kind = start loads both endpoints
// and the color of a new line and gives no pixel; a start also aborts any line
// in progress. kind = next emits the current pixel of the active line on
// pixel_out and steps the line; a next beat while no line is active is dropped.
// A line of major distance D gives D + 2 pixels, the first one twice, and the
// final pixel, always the second endpoint, carries last.
// Path: a next beat accepted into the input register shows its pixel on pixel_out
// once the output register takes it, unless a stalled pixel holds it back.
// Throughput: one beat per cycle while pixel_out is empty or taken; every step is
// one add and compare per axis in the loop through the line state registers.
// Stall: line_in.ready stays high while pixel_out is empty or taken; while a
// pixel waits on pixel_out, one more beat is held in the input register and
// line_in.ready falls until the pixel is taken.
// Reset: arst_n clears the valid flags of both registers and returns the engine
// to idle with no line active.
module line_pixel_generator_core (
	input  logic      clk,
	input  logic      arst_n,
	lpg_in_if.sink    line_in,
	lpg_out_if.source pixel_out
);

	logic            valid_s1;
	lpg_pkg::item_t  item_s1;
	logic            out_valid_q;
	lpg_pkg::pixel_t pixel_q;
	logic            out_free;
	logic            advance;
	logic            emit;
	lpg_pkg::pixel_t pixel;

	assign out_free      = !out_valid_q || pixel_out.ready;
	assign advance       = valid_s1 && out_free;
	assign line_in.ready = !valid_s1 || out_free;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (line_in.ready) begin
			valid_s1 <= line_in.valid;
		end
	end

	always_ff @(posedge clk) begin
		if (line_in.ready && line_in.valid) begin
			item_s1.kind    <= line_in.kind;
			item_s1.x_start <= line_in.x_start;
			item_s1.y_start <= line_in.y_start;
			item_s1.x_end   <= line_in.x_end;
			item_s1.y_end   <= line_in.y_end;
			item_s1.color   <= line_in.color;
		end
	end

	lpg_engine u_engine (
		.clk    (clk),
		.arst_n (arst_n),
		.go     (advance),
		.item   (item_s1),
		.emit   (emit),
		.pixel  (pixel)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (out_free) begin
			out_valid_q <= emit;
		end
	end

	always_ff @(posedge clk) begin
		if (out_free && emit) begin
			pixel_q <= pixel;
		end
	end

	assign pixel_out.valid       = out_valid_q;
	assign pixel_out.pixel_x     = pixel_q.x;
	assign pixel_out.pixel_y     = pixel_q.y;
	assign pixel_out.pixel_color = pixel_q.color;
	assign pixel_out.last        = pixel_q.last;

endmodule

// ===== rtl/lpg_checker.sv =====
// Port-level assertions for the line pixel generator, bound to the top level.
module lpg_checker (
	input logic            clk,
	input logic            arst_n,
	input logic            in_valid,
	input logic            in_ready,
	input logic            out_valid,
	input logic            out_ready,
	input lpg_pkg::coord_t out_x,
	input lpg_pkg::coord_t out_y,
	input lpg_pkg::color_t out_color,
	input logic            out_last
);

	a_out_hold_valid: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid)
		else $error("pixel beat dropped while stalled");

	a_out_hold_data: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> $stable(out_x) && $stable(out_y) &&
			$stable(out_color) && $stable(out_last))
		else $error("pixel payload changed while stalled");

	a_ready_when_free: assert property (@(posedge clk) disable iff (!arst_n)
		(!out_valid || out_ready) |-> in_ready)
		else $error("command channel blocked while pixel channel is free");

	a_no_invented_pixel: assert property (@(posedge clk) disable iff (!arst_n)
		(!in_valid && !out_valid && $past(!in_valid && !out_valid)) |=> !out_valid)
		else $error("pixel beat without a pending command");

endmodule

bind line_pixel_generator_core lpg_checker u_lpg_checker (
	.clk       (clk),
	.arst_n    (arst_n),
	.in_valid  (line_in.valid),
	.in_ready  (line_in.ready),
	.out_valid (pixel_out.valid),
	.out_ready (pixel_out.ready),
	.out_x     (pixel_out.pixel_x),
	.out_y     (pixel_out.pixel_y),
	.out_color (pixel_out.pixel_color),
	.out_last  (pixel_out.last)
);

// ===== tb/sv/line_pixel_generator_core_test.sv =====
// Self-checking testbench for the line pixel generator: directed lines, random lines, pixel check.
`timescale 1ns / 100ps

module line_pixel_generator_core_test;

	localparam int COORD_TOP    = (1 << lpg_pkg::COORD_BITS) - 1;
	localparam int ITEM_TARGET  = 1450;
	localparam int HOLD_CYCLES  = 200;
	localparam int STALL_LIMIT  = 2000;
	localparam int DRAIN_CYCLES = 40;
	localparam int PRINT_CAP    = 100;

	typedef struct packed {
		lpg_pkg::item_t  cmd;
		logic            typed;
		lpg_pkg::pixel_t px;
	} script_row_t;

	logic clk = 1'b0;
	logic arst_n;

	lpg_in_if  line_in ();
	lpg_out_if pixel_out ();

	line_pixel_generator_core uut (
		.clk      (clk),
		.arst_n   (arst_n),
		.line_in  (line_in),
		.pixel_out(pixel_out)
	);

	// line state of the predictor
	logic            line_on;
	lpg_pkg::coord_t pos_x, pos_y;
	lpg_pkg::dir_t   dir_x, dir_y;
	lpg_pkg::coord_t run_dx, run_dy, run_major;
	lpg_pkg::err_t   acc_x, acc_y;
	lpg_pkg::err_t   emitted;
	lpg_pkg::color_t ink;

	lpg_pkg::pixel_t pixels_due[$];
	bit              rush;
	int              hold_asks;
	int              worked;
	int              mismatches = 0;
	int              stuck = 0;

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	task automatic report_mismatch(input string what);
		if (mismatches < PRINT_CAP)
			$display("MISMATCH at %0t: %s", $time, what);
		mismatches++;
	endtask

	function automatic void axis_span(input lpg_pkg::coord_t a, input lpg_pkg::coord_t b,
			output lpg_pkg::coord_t mag, output lpg_pkg::dir_t d);
		if (b > a) begin
			mag = b - a;
			d   = lpg_pkg::DIR_POS;
		end else if (b == a) begin
			mag = '0;
			d   = lpg_pkg::DIR_NONE;
		end else begin
			mag = a - b;
			d   = lpg_pkg::DIR_NEG;
		end
	endfunction

	function automatic lpg_pkg::coord_t step_coord(input lpg_pkg::coord_t c,
			input lpg_pkg::dir_t d);
		if (d == lpg_pkg::DIR_POS)
			return c + lpg_pkg::coord_t'(1);
		if (d == lpg_pkg::DIR_NEG)
			return c - lpg_pkg::coord_t'(1);
		return c;
	endfunction

	function automatic bit rasterize(input lpg_pkg::item_t cmd, output lpg_pkg::pixel_t px);
		px = '0;
		if (cmd.kind == lpg_pkg::KIND_START) begin
			axis_span(cmd.x_start, cmd.x_end, run_dx, dir_x);
			axis_span(cmd.y_start, cmd.y_end, run_dy, dir_y);
			run_major = (run_dx > run_dy) ? run_dx : run_dy;
			pos_x     = cmd.x_start;
			pos_y     = cmd.y_start;
			ink       = cmd.color;
			acc_x     = '0;
			acc_y     = '0;
			emitted   = '0;
			line_on   = 1'b1;
			return 1'b0;
		end
		if (!line_on)
			return 1'b0;
		px.x     = pos_x;
		px.y     = pos_y;
		px.color = ink;
		px.last  = (int'(emitted) >= int'(run_major) + 1);
		if (px.last) begin
			line_on = 1'b0;
			return 1'b1;
		end
		emitted = emitted + lpg_pkg::err_t'(1);
		acc_x   = acc_x + lpg_pkg::err_t'(run_dx);
		acc_y   = acc_y + lpg_pkg::err_t'(run_dy);
		if (acc_x > lpg_pkg::err_t'(run_major)) begin
			acc_x = acc_x - lpg_pkg::err_t'(run_major);
			pos_x = step_coord(pos_x, dir_x);
		end
		if (acc_y > lpg_pkg::err_t'(run_major)) begin
			acc_y = acc_y - lpg_pkg::err_t'(run_major);
			pos_y = step_coord(pos_y, dir_y);
		end
		return 1'b1;
	endfunction

	function automatic script_row_t start_row(input int xs, input int ys, input int xe,
			input int ye, input int c);
		script_row_t row;
		row             = '0;
		row.cmd.kind    = lpg_pkg::KIND_START;
		row.cmd.x_start = lpg_pkg::coord_t'(xs);
		row.cmd.y_start = lpg_pkg::coord_t'(ys);
		row.cmd.x_end   = lpg_pkg::coord_t'(xe);
		row.cmd.y_end   = lpg_pkg::coord_t'(ye);
		row.cmd.color   = lpg_pkg::color_t'(c);
		return row;
	endfunction

	function automatic script_row_t step_row(input logic typed, input int x, input int y,
			input int c, input logic last);
		script_row_t row;
		row          = '0;
		row.cmd.kind = lpg_pkg::KIND_NEXT;
		row.typed    = typed;
		row.px.x     = lpg_pkg::coord_t'(x);
		row.px.y     = lpg_pkg::coord_t'(y);
		row.px.color = lpg_pkg::color_t'(c);
		row.px.last  = last;
		return row;
	endfunction

	function automatic lpg_pkg::item_t scatter_cmd(input logic kind);
		lpg_pkg::item_t cmd;
		cmd.kind    = kind;
		cmd.x_start = lpg_pkg::coord_t'($urandom_range(0, COORD_TOP));
		cmd.y_start = lpg_pkg::coord_t'($urandom_range(0, COORD_TOP));
		cmd.x_end   = lpg_pkg::coord_t'($urandom_range(0, COORD_TOP));
		cmd.y_end   = lpg_pkg::coord_t'($urandom_range(0, COORD_TOP));
		cmd.color   = lpg_pkg::color_t'($urandom_range(0, 16'hFFFF));
		return cmd;
	endfunction

	function automatic lpg_pkg::coord_t reach(input lpg_pkg::coord_t base, input int span);
		int spot;
		spot = int'(base) + int'($urandom_range(0, 2 * span)) - span;
		if (spot < 0)
			spot = 0;
		if (spot > COORD_TOP)
			spot = COORD_TOP;
		return lpg_pkg::coord_t'(spot);
	endfunction

	function automatic lpg_pkg::item_t line_cmd();
		lpg_pkg::item_t cmd;
		int             span;
		cmd  = scatter_cmd(lpg_pkg::KIND_START);
		span = ($urandom_range(0, 7) == 0) ? 120 : 12;
		if ($urandom_range(0, 15) == 0)
			cmd.x_start = $urandom_range(0, 1) ? lpg_pkg::coord_t'(COORD_TOP) : '0;
		if ($urandom_range(0, 15) == 0)
			cmd.y_start = $urandom_range(0, 1) ? lpg_pkg::coord_t'(COORD_TOP) : '0;
		cmd.x_end = reach(cmd.x_start, span);
		cmd.y_end = reach(cmd.y_start, span);
		return cmd;
	endfunction

	task automatic send_command(input lpg_pkg::item_t cmd, input logic typed,
			input lpg_pkg::pixel_t typed_px);
		int              gap;
		bit              useful;
		lpg_pkg::pixel_t px;
		gap = rush ? 0 : $urandom_range(0, 18);
		if (gap > 0) begin
			line_in.valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		line_in.valid   <= 1'b1;
		line_in.kind    <= cmd.kind;
		line_in.x_start <= cmd.x_start;
		line_in.y_start <= cmd.y_start;
		line_in.x_end   <= cmd.x_end;
		line_in.y_end   <= cmd.y_end;
		line_in.color   <= cmd.color;
		do @(posedge clk); while (line_in.ready !== 1'b1);
		useful = (cmd.kind == lpg_pkg::KIND_START) || line_on;
		if (rasterize(cmd, px))
			pixels_due.push_back(typed ? typed_px : px);
		if (useful)
			worked++;
	endtask

	// pixel check
	always @(posedge clk) begin
		lpg_pkg::pixel_t due;
		if (arst_n && pixel_out.valid && pixel_out.ready) begin
			if (pixels_due.size() == 0) begin
				report_mismatch($sformatf("pixel (%0d,%0d) with nothing due",
					pixel_out.pixel_x, pixel_out.pixel_y));
			end else begin
				due = pixels_due.pop_front();
				if (pixel_out.pixel_x !== due.x)
					report_mismatch($sformatf("pixel_x %0d, want %0d",
						pixel_out.pixel_x, due.x));
				if (pixel_out.pixel_y !== due.y)
					report_mismatch($sformatf("pixel_y %0d, want %0d",
						pixel_out.pixel_y, due.y));
				if (pixel_out.pixel_color !== due.color)
					report_mismatch($sformatf("pixel_color %h, want %h",
						pixel_out.pixel_color, due.color));
				if (pixel_out.last !== due.last)
					report_mismatch($sformatf("last %b, want %b at (%0d,%0d)",
						pixel_out.last, due.last, due.x, due.y));
			end
		end
	end

	always @(posedge clk) begin
		if ((line_in.valid && line_in.ready) || (pixel_out.valid && pixel_out.ready))
			stuck <= 0;
		else
			stuck <= stuck + 1;
	end

	initial begin
		wait (stuck >= STALL_LIMIT);
		$display("line_pixel_generator_core verification failed");
		$finish;
	end

	// pixel sink: random stalls, long hold-off on request
	initial begin
		int stall;
		int holds_done;
		holds_done = 0;
		wait (arst_n === 1'b1);
		@(posedge clk);
		forever begin
			stall = rush ? 0 : $urandom_range(0, 18);
			if (hold_asks > holds_done) begin
				holds_done++;
				stall = HOLD_CYCLES;
			end
			if (stall > 0) begin
				pixel_out.ready <= 1'b0;
				repeat (stall) @(posedge clk);
			end
			pixel_out.ready <= 1'b1;
			do @(posedge clk); while (pixel_out.valid !== 1'b1);
		end
	end

	initial begin
		script_row_t script[$];
		int          shape;
		int          pixels;
		line_on    = 1'b0;
		pos_x      = '0;
		pos_y      = '0;
		dir_x      = lpg_pkg::DIR_NONE;
		dir_y      = lpg_pkg::DIR_NONE;
		run_dx     = '0;
		run_dy     = '0;
		run_major  = '0;
		acc_x      = '0;
		acc_y      = '0;
		emitted    = '0;
		ink        = '0;
		rush       = 1'b0;
		hold_asks  = 0;
		worked     = 0;

		arst_n            <= 1'b0;
		line_in.valid     <= 1'b0;
		line_in.kind      <= lpg_pkg::KIND_START;
		line_in.x_start   <= '0;
		line_in.y_start   <= '0;
		line_in.x_end     <= '0;
		line_in.y_end     <= '0;
		line_in.color     <= '0;
		pixel_out.ready   <= 1'b0;
		repeat (9) @(posedge clk);
		arst_n <= 1'b1;

		script = '{
			step_row(1'b0, 0, 0, 0, 1'b0),
			start_row(0, 0, 0, 0, 16'h0000),
			step_row(1'b1, 0, 0, 16'h0000, 1'b0),
			step_row(1'b1, 0, 0, 16'h0000, 1'b1),
			step_row(1'b0, 0, 0, 0, 1'b0),
			start_row(COORD_TOP, COORD_TOP, COORD_TOP, COORD_TOP, 16'hFFFF),
			step_row(1'b1, COORD_TOP, COORD_TOP, 16'hFFFF, 1'b0),
			step_row(1'b1, COORD_TOP, COORD_TOP, 16'hFFFF, 1'b1),
			start_row(COORD_TOP, 0, 0, COORD_TOP, 16'h1234),
			step_row(1'b1, COORD_TOP, 0, 16'h1234, 1'b0),
			step_row(1'b0, 0, 0, 0, 1'b0),
			step_row(1'b0, 0, 0, 0, 1'b0),
			start_row(5, 7, 2, 9, 16'hBEEF),
			step_row(1'b1, 5, 7, 16'hBEEF, 1'b0),
			step_row(1'b0, 0, 0, 0, 1'b0),
			step_row(1'b0, 0, 0, 0, 1'b0),
			step_row(1'b0, 0, 0, 0, 1'b0),
			step_row(1'b1, 2, 9, 16'hBEEF, 1'b1),
			start_row(3, 0, 3, 2, 16'hFFFF),
			step_row(1'b0, 0, 0, 0, 1'b0),
			step_row(1'b0, 0, 0, 0, 1'b0),
			step_row(1'b0, 0, 0, 0, 1'b0),
			step_row(1'b1, 3, 2, 16'hFFFF, 1'b1)
		};
		foreach (script[i])
			send_command(script[i].cmd, script[i].typed, script[i].px);

		while (worked < ITEM_TARGET) begin
			if (hold_asks < 2 && worked > 400 + 600 * hold_asks)
				hold_asks++;
			rush  = ($urandom_range(0, 4) == 0);
			shape = $urandom_range(0, 9);
			send_command(line_cmd(), 1'b0, '0);
			pixels = int'(run_major) + 2;
			if (shape == 0)
				pixels = $urandom_range(0, pixels - 1);
			else if (shape == 1)
				pixels += $urandom_range(1, 3);
			repeat (pixels)
				send_command(scatter_cmd(lpg_pkg::KIND_NEXT), 1'b0, '0);
			if (shape == 2)
				repeat ($urandom_range(1, 6))
					send_command(scatter_cmd(1'($urandom_range(0, 1))), 1'b0, '0);
		end
		line_in.valid <= 1'b0;

		while (pixels_due.size() != 0)
			@(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);
		if (mismatches == 0)
			$display("line_pixel_generator_core verification clean");
		else
			$display("line_pixel_generator_core verification failed");
		$finish;
	end

endmodule
